// ===== hdl/mexpm31_pkg.sv =====
// Shared constants and controller/datapath command and status types for the mod 2^31-1 exponentiator.
package mexpm31_pkg;

    // Field widths
    localparam int unsigned BASE_W  = 32;
    localparam int unsigned EXP_W   = 32;
    localparam int unsigned RES_W   = 31;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 32;

    // The Mersenne prime 2^31-1
    localparam logic [RES_W-1:0] MODULUS = {RES_W{1'b1}};

    // One shift-add step per multiplier bit
    localparam int unsigned MUL_STEPS = RES_W;
    localparam int unsigned CNT_W     = $clog2(MUL_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture a new request, reduce the base, acc = 1
        logic start;    // clear product, load multiplicand and multiplier
        logic op_sqr;   // with start: multiplier is sq (square) instead of acc
        logic step;     // one double-and-add step of the product
        logic wr_acc;   // acc <= product
        logic wr_sq;    // sq <= product, exponent >>= 1
        logic wr_out;   // result register <= acc
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic exp_zero; // remaining exponent is zero
        logic exp_lsb;  // current exponent bit
    } t_sts;

endpackage

// ===== hdl/mexpm31_dpath.sv =====
// Datapath: operand registers, shift-and-add modular multiplier and result register.
module mexpm31_dpath (
    input  logic                          i_clk,
    input  mexpm31_pkg::t_cmd             i_cmd,
    input  logic [mexpm31_pkg::BASE_W-1:0] i_base,
    input  logic [mexpm31_pkg::EXP_W-1:0]  i_exponent,
    output mexpm31_pkg::t_sts             o_sts,
    output logic [mexpm31_pkg::RES_W-1:0]  o_power
);

    // (a + b) mod p for a, b < p; 2^31 folds to 1
    function automatic logic [mexpm31_pkg::RES_W-1:0] add_mod(
        input logic [mexpm31_pkg::RES_W-1:0] a,
        input logic [mexpm31_pkg::RES_W-1:0] b
    );
        logic [mexpm31_pkg::RES_W:0] s;
        logic [mexpm31_pkg::RES_W-1:0] r;
        s = {1'b0, a} + {1'b0, b};
        if (s[mexpm31_pkg::RES_W]) begin
            r = s[mexpm31_pkg::RES_W-1:0] + mexpm31_pkg::RES_W'(1);
        end else if (s[mexpm31_pkg::RES_W-1:0] == mexpm31_pkg::MODULUS) begin
            r = '0;
        end else begin
            r = s[mexpm31_pkg::RES_W-1:0];
        end
        return r;
    endfunction

    logic [mexpm31_pkg::RES_W-1:0] r_acc;
    logic [mexpm31_pkg::RES_W-1:0] r_sq;
    logic [mexpm31_pkg::EXP_W-1:0] r_exp;
    logic [mexpm31_pkg::RES_W-1:0] r_mx;
    logic [mexpm31_pkg::RES_W-1:0] r_my;
    logic [mexpm31_pkg::RES_W-1:0] r_prod;
    logic [mexpm31_pkg::RES_W-1:0] r_power;

    logic [mexpm31_pkg::RES_W-1:0] n_base;
    logic [mexpm31_pkg::RES_W-1:0] n_prod;
    logic [mexpm31_pkg::RES_W-1:0] dbl;
    logic [mexpm31_pkg::RES_W-1:0] addend;

    // Base mod p: fold bit 31 onto bit 0 (base[30:0] + base[31] < 2p)
    always_comb begin
        n_base = add_mod(
            (i_base[mexpm31_pkg::RES_W-1:0] == mexpm31_pkg::MODULUS)
                ? '0 : i_base[mexpm31_pkg::RES_W-1:0],
            mexpm31_pkg::RES_W'(i_base[mexpm31_pkg::BASE_W-1]));
    end

    // Horner step, multiplier MSB first: 2*prod is a 31-bit rotate mod p
    always_comb begin
        dbl    = {r_prod[mexpm31_pkg::RES_W-2:0], r_prod[mexpm31_pkg::RES_W-1]};
        addend = r_my[mexpm31_pkg::RES_W-1] ? r_mx : '0;
        n_prod = add_mod(dbl, addend);
    end

    // Operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= mexpm31_pkg::RES_W'(1);
            r_sq  <= n_base;
            r_exp <= i_exponent;
        end
        if (i_cmd.start) begin
            r_mx   <= r_sq;
            r_my   <= i_cmd.op_sqr ? r_sq : r_acc;
            r_prod <= '0;
        end else if (i_cmd.step) begin
            r_my   <= {r_my[mexpm31_pkg::RES_W-2:0], 1'b0};
            r_prod <= n_prod;
        end
        if (i_cmd.wr_acc) begin
            r_acc <= r_prod;
        end
        if (i_cmd.wr_sq) begin
            r_sq  <= r_prod;
            r_exp <= {1'b0, r_exp[mexpm31_pkg::EXP_W-1:1]};
        end
        if (i_cmd.wr_out) begin
            r_power <= r_acc;
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_power        = r_power;

endmodule

// ===== hdl/mexpm31_ctrl.sv =====
// Controller: sequences exponent bits, multiply steps and the stream handshakes.
module mexpm31_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mexpm31_pkg::t_sts i_sts,
    output mexpm31_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_ACC_WB = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_SQ_WB  = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [mexpm31_pkg::CNT_W-1:0] r_cnt;
    logic [mexpm31_pkg::CNT_W-1:0] n_cnt;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_cnt = '0;
                if (i_sts.exp_zero) begin
                    // all exponent bits consumed: hand acc to the output register
                    if (out_free) begin
                        o_cmd.wr_out = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else if (i_sts.exp_lsb) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_MUL;
                end else begin
                    o_cmd.start  = 1'b1;
                    o_cmd.op_sqr = 1'b1;
                    n_state      = ST_SQR;
                end
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + mexpm31_pkg::CNT_W'(1);
                if (r_cnt == mexpm31_pkg::CNT_LAST) begin
                    n_state = ST_ACC_WB;
                end
            end
            ST_ACC_WB: begin
                // acc done; square starts from the unchanged sq
                o_cmd.wr_acc = 1'b1;
                o_cmd.start  = 1'b1;
                o_cmd.op_sqr = 1'b1;
                n_cnt        = '0;
                n_state      = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + mexpm31_pkg::CNT_W'(1);
                if (r_cnt == mexpm31_pkg::CNT_LAST) begin
                    n_state = ST_SQ_WB;
                end
            end
            ST_SQ_WB: begin
                o_cmd.wr_sq = 1'b1;
                n_state     = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/modular_exponentiation_mersenne31_core.sv =====
// Top level: base^exponent mod 2^31-1 with stream input and output.
//
// Computes power = base^exponent mod 2147483647 by right-to-left square and
// multiply. The base is reduced mod p when the request is taken. Each exponent
// bit takes a check state, a shift-add multiply when the bit is set and a
// square, each product followed by its write-back state; scanning stops once
// the remaining exponent is zero, and the result register is loaded as soon as
// it is free. The single shared multiplier handles one multiplier bit per
// cycle. One request is processed at a time, and the next request is taken in
// the idle state. A new request is accepted as soon as the previous result sits
// in the output register, even if it is not yet taken.
module modular_exponentiation_mersenne31_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mexpm31_pkg::S_DATA_W-1:0]    s_axis_tdata,  // base[31:0], exponent[63:32]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mexpm31_pkg::M_DATA_W-1:0]    m_axis_tdata   // power[30:0], zero pad[31]
);

    mexpm31_pkg::t_cmd              cmd;
    mexpm31_pkg::t_sts              sts;
    logic [mexpm31_pkg::RES_W-1:0]  power;

    mexpm31_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mexpm31_dpath u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_base     (s_axis_tdata[mexpm31_pkg::BASE_W-1:0]),
        .i_exponent (s_axis_tdata[mexpm31_pkg::BASE_W +: mexpm31_pkg::EXP_W]),
        .o_sts      (sts),
        .o_power    (power)
    );

    assign m_axis_tdata = {{(mexpm31_pkg::M_DATA_W - mexpm31_pkg::RES_W){1'b0}}, power};

    // A new request makes the block busy on the next cycle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !s_axis_tready)
        else $error("request accepted but block still ready");

    // Result register is written only when free
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

    // Result is written only after the whole exponent has been consumed
    a_out_exp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_out |-> sts.exp_zero)
        else $error("result written with exponent bits left");

    // A delivered power is fully reduced
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (power != mexpm31_pkg::MODULUS))
        else $error("result not reduced mod p");

endmodule
